### src/bhc_pkg.sv
// Package for the hall commutation / PI speed block: widths, register map,
// divider handshake structs and the six-step commutation table.
// No dependencies.
`default_nettype none

package bhc_pkg;

    localparam int TIMER_WIDTH    = 16;
    localparam int SAMPLE_WIDTH   = 10;
    localparam int POT_GAIN       = 4;
    localparam int INDEX_POSITION = 1;

    localparam int DUTY_W   = 10;
    localparam int SPEED_W  = 15;
    localparam int FACTOR_W = 24;
    localparam int GAIN_W   = 16;
    localparam int ERR_W    = 16;
    localparam int CROSS_W  = 4;
    localparam int PADDR_W  = 5;

    localparam logic [DUTY_W-1:0]  DUTY_RESET  = 10'd100;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 15'h7FFF;

    // opcodes carried in tuser
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_HALL = 2'd1,
        OP_POT  = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    // register indexes, byte address 4*index
    typedef enum logic [2:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_INTEG_GAIN   = 3'd1,
        REG_DUTY_FLOOR   = 3'd2,
        REG_DUTY_CEILING = 3'd3,
        REG_SPEED_FACTOR = 3'd4,
        REG_POLE_PAIRS   = 3'd5,
        REG_ROTATION_DIR = 3'd6,
        REG_RUN_ENABLE   = 3'd7
    } t_reg_index;

    typedef struct packed {
        logic                  start;
        logic [FACTOR_W-1:0]   dividend;
        logic [TIMER_WIDTH-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [FACTOR_W-1:0] quot;
    } t_div_rsp;

    function automatic logic [15:0] step_pattern(input logic dir, input logic [2:0] hall);
        logic [15:0] pat;
        pat = 16'h0000;
        if (!dir) begin
            unique case (hall)
                3'd1:    pat = 16'h2001;
                3'd2:    pat = 16'h0810;
                3'd3:    pat = 16'h0801;
                3'd4:    pat = 16'h0204;
                3'd5:    pat = 16'h2004;
                3'd6:    pat = 16'h0210;
                default: pat = 16'h0000;
            endcase
        end else begin
            unique case (hall)
                3'd1:    pat = 16'h0210;
                3'd2:    pat = 16'h2004;
                3'd3:    pat = 16'h0204;
                3'd4:    pat = 16'h0801;
                3'd5:    pat = 16'h0810;
                3'd6:    pat = 16'h2001;
                default: pat = 16'h0000;
            endcase
        end
        return pat;
    endfunction

endpackage

`default_nettype wire

### src/bhc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on bhc_pkg.
`default_nettype none

module bhc_div
    import bhc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(FACTOR_W);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic [TIMER_WIDTH-1:0] r_rem;
    logic [TIMER_WIDTH-1:0] r_div;
    logic [FACTOR_W-1:0]    r_q;

    logic [TIMER_WIDTH:0]   n_trial;
    logic                   n_bit;
    logic [TIMER_WIDTH-1:0] n_rem;

    always_comb begin
        n_trial = {r_rem, r_q[FACTOR_W-1]};
        n_bit   = (n_trial >= {1'b0, r_div});
        n_rem   = n_bit ? TIMER_WIDTH'(n_trial - {1'b0, r_div}) : n_trial[TIMER_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_div  <= i_req.divisor;
                r_q    <= i_req.dividend;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= {r_q[FACTOR_W-2:0], n_bit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FACTOR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

`default_nettype wire

### src/bldc_hall_commutation_pi_speed.sv
// Six-step hall commutation with a PI speed loop. One item at a time. For a tick,
// hall or unused opcode the state goes from S_EXEC to S_PUSH, where the result is
// registered. A pot sample goes through the divider start and its 24 bit-serial
// steps, then two passes through one shared 17x16 multiplier, a sum and the duty
// clamp before S_PUSH; when the averaged period is zero the divider is skipped.
// Every accepted item yields one result that snapshots the state; a new item is
// taken while that result waits downstream. Output backpressure on a second
// result stalls the block in S_PUSH.
// Depends on bhc_pkg and bhc_div.
`default_nettype none

module bldc_hall_commutation_pi_speed
    import bhc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // APB configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    // input events
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [15:0]        s_axis_tdata,  // hall_code[2:0], pot_sample[12:3]
    input  wire logic [1:0]         s_axis_tuser,  // opcode[1:0]
    // results
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [79:0]             m_axis_tdata   // phase_override[15:0], duty_out[25:16],
                                                   // avg_period[41:26], measured_speed[56:42],
                                                   // speed_error_out[72:57]
);

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_DIV_START, S_DIV_WAIT, S_ERR,
        S_MUL_P, S_MUL_I, S_SUM, S_CLAMP, S_PUSH
    } t_state;

    localparam int ACC_W  = 2 * GAIN_W + 2;
    localparam int PROD_W = GAIN_W + 1 + ERR_W;
    localparam int DES_W  = SAMPLE_WIDTH + 5;

    // configuration
    logic [GAIN_W-1:0]   r_prop_gain, r_integ_gain;
    logic [DUTY_W-1:0]   r_duty_floor, r_duty_ceiling;
    logic [FACTOR_W-1:0] r_speed_factor;
    logic [CROSS_W-1:0]  r_pole_pairs;
    logic                r_rotation_dir, r_run_enable;

    // block state
    t_state                  r_state;
    t_opcode                 r_op;
    logic [2:0]              r_hall;
    logic [SAMPLE_WIDTH-1:0] r_pot;
    logic [TIMER_WIDTH-1:0]  r_counter, r_average;
    logic [CROSS_W-1:0]      r_crossings;
    logic signed [ERR_W-1:0] r_integ, r_err;
    logic [DUTY_W-1:0]       r_duty;
    logic [15:0]             r_override;
    logic [SPEED_W-1:0]      r_speed;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                    r_out_valid;
    logic [79:0]             r_out_data;
    logic                    r_div_start;

    t_div_req div_req;
    t_div_rsp div_rsp;

    bhc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign div_req.start    = r_div_start;
    assign div_req.dividend = r_speed_factor;
    assign div_req.divisor  = r_average;

    logic cfg_write;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb begin
        prdata = '0;
        unique case (t_reg_index'(paddr[4:2]))
            REG_PROP_GAIN:    prdata = 32'(r_prop_gain);
            REG_INTEG_GAIN:   prdata = 32'(r_integ_gain);
            REG_DUTY_FLOOR:   prdata = 32'(r_duty_floor);
            REG_DUTY_CEILING: prdata = 32'(r_duty_ceiling);
            REG_SPEED_FACTOR: prdata = 32'(r_speed_factor);
            REG_POLE_PAIRS:   prdata = 32'(r_pole_pairs);
            REG_ROTATION_DIR: prdata = 32'(r_rotation_dir);
            REG_RUN_ENABLE:   prdata = 32'(r_run_enable);
            default:          prdata = '0;
        endcase
    end

    // speed saturation after the divider
    logic [SPEED_W-1:0] n_speed;
    assign n_speed = (div_rsp.quot > FACTOR_W'(SPEED_MAX)) ? SPEED_MAX
                                                           : div_rsp.quot[SPEED_W-1:0];

    // speed error and integral
    logic [DES_W-1:0]        n_desired;
    logic signed [DES_W+2:0] n_diff;
    logic signed [ERR_W-1:0] n_err;
    logic signed [ERR_W:0]   n_isum;
    logic signed [ERR_W-1:0] n_integ;

    always_comb begin
        n_desired = DES_W'(r_pot) * DES_W'(POT_GAIN);
        n_diff    = $signed({3'b000, n_desired}) - $signed({3'b000, r_speed});
        if (n_diff > $signed((DES_W+3)'(32767)))
            n_err = 16'sh7FFF;
        else if (n_diff < -$signed((DES_W+3)'(32768)))
            n_err = 16'sh8000;
        else
            n_err = ERR_W'(n_diff);
        n_isum = $signed({r_integ[ERR_W-1], r_integ}) + $signed({n_err[ERR_W-1], n_err});
        if (n_isum > $signed(17'sd32767))
            n_integ = 16'sh7FFF;
        else if (n_isum < -$signed(17'sd32768))
            n_integ = 16'sh8000;
        else
            n_integ = ERR_W'(n_isum);
    end

    // shared multiplier: gain (unsigned) times error or integral (signed)
    logic signed [GAIN_W:0]   mul_a;
    logic signed [ERR_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;

    always_comb begin
        mul_a = (r_state == S_MUL_I) ? $signed({1'b0, r_integ_gain}) : $signed({1'b0, r_prop_gain});
        mul_b = (r_state == S_MUL_I) ? r_integ : r_err;
        mul_p = mul_a * mul_b;
    end

    // duty update and clamps, floor first then ceiling
    logic signed [ACC_W-17:0] n_step;
    logic signed [ACC_W-16:0] n_dsum, n_d1, n_d2;
    logic                     n_clr;

    always_comb begin
        n_step = r_acc[ACC_W-1:16];
        n_dsum = $signed({{(ACC_W-15-DUTY_W){1'b0}}, r_duty}) + n_step;
        n_clr  = 1'b0;
        n_d1   = n_dsum;
        if (n_dsum < $signed({{(ACC_W-15-DUTY_W){1'b0}}, r_duty_floor})) begin
            n_d1  = $signed({{(ACC_W-15-DUTY_W){1'b0}}, r_duty_floor});
            n_clr = 1'b1;
        end
        n_d2 = n_d1;
        if (n_d1 > $signed({{(ACC_W-15-DUTY_W){1'b0}}, r_duty_ceiling})) begin
            n_d2  = $signed({{(ACC_W-15-DUTY_W){1'b0}}, r_duty_ceiling});
            n_clr = 1'b1;
        end
    end

    logic [TIMER_WIDTH:0] n_avg_sum;
    assign n_avg_sum = {1'b0, r_average} + {1'b0, r_counter};

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain    <= 16'd750;
            r_integ_gain   <= 16'd20;
            r_duty_floor   <= 10'd50;
            r_duty_ceiling <= 10'd512;
            r_speed_factor <= 24'd2343750;
            r_pole_pairs   <= 4'd5;
            r_rotation_dir <= 1'b0;
            r_run_enable   <= 1'b0;
            r_state        <= S_IDLE;
            r_op           <= OP_NONE;
            r_counter      <= '0;
            r_average      <= '0;
            r_crossings    <= CROSS_W'(1);
            r_integ        <= '0;
            r_err          <= '0;
            r_duty         <= DUTY_RESET;
            r_override     <= '0;
            r_speed        <= '0;
            r_out_valid    <= 1'b0;
            r_div_start    <= 1'b0;
        end else begin
            // one-cycle start pulse for the divider when the period is nonzero
            r_div_start <= (r_state == S_DIV_START) && (r_average != '0);
            if (cfg_write) begin
                unique case (t_reg_index'(paddr[4:2]))
                    REG_PROP_GAIN:    r_prop_gain    <= pwdata[GAIN_W-1:0];
                    REG_INTEG_GAIN:   r_integ_gain   <= pwdata[GAIN_W-1:0];
                    REG_DUTY_FLOOR:   r_duty_floor   <= pwdata[DUTY_W-1:0];
                    REG_DUTY_CEILING: r_duty_ceiling <= pwdata[DUTY_W-1:0];
                    REG_SPEED_FACTOR: r_speed_factor <= pwdata[FACTOR_W-1:0];
                    REG_POLE_PAIRS:   r_pole_pairs   <= pwdata[CROSS_W-1:0];
                    REG_ROTATION_DIR: r_rotation_dir <= pwdata[0];
                    REG_RUN_ENABLE:   r_run_enable   <= pwdata[0];
                    default: ;
                endcase
            end
            if (r_state == S_PUSH && (!r_out_valid || m_axis_tready))
                r_out_valid <= 1'b1;
            else if (m_axis_tready)
                r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op    <= t_opcode'(s_axis_tuser);
                        r_hall  <= s_axis_tdata[2:0];
                        r_pot   <= s_axis_tdata[12:3];
                        r_state <= (t_opcode'(s_axis_tuser) == OP_POT) ? S_DIV_START : S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_op == OP_TICK) begin
                        r_counter <= r_counter + 1'b1;
                    end else if (r_op == OP_HALL) begin
                        r_override <= r_run_enable ? step_pattern(r_rotation_dir, r_hall) : '0;
                        if (r_hall == 3'(INDEX_POSITION)) begin
                            if (r_crossings == r_pole_pairs) begin
                                r_average   <= n_avg_sum[TIMER_WIDTH:1];
                                r_counter   <= '0;
                                r_crossings <= CROSS_W'(1);
                            end else begin
                                r_crossings <= r_crossings + 1'b1;
                            end
                        end
                    end
                    r_state <= S_PUSH;
                end
                S_DIV_START: begin
                    if (r_average == '0) begin
                        r_speed <= '0;
                        r_state <= S_ERR;
                    end else begin
                        r_state <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT: begin
                    if (div_rsp.done) begin
                        r_speed <= n_speed;
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_err   <= n_err;
                    r_integ <= n_integ;
                    r_state <= S_MUL_P;
                end
                S_MUL_P: begin
                    r_prod  <= mul_p;
                    r_state <= S_MUL_I;
                end
                S_MUL_I: begin
                    r_acc   <= ACC_W'(r_prod);
                    r_prod  <= mul_p;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_acc   <= r_acc + ACC_W'(r_prod);
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_duty <= n_d2[DUTY_W-1:0];
                    if (n_clr)
                        r_integ <= '0;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_data  <= {7'b0, r_err, r_speed, r_average, r_duty, r_override};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a transfer always starts work
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");

    // divider completes only while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV_WAIT))
        else $error("divider done outside wait state");

    // a clamp clears the integral
    a_clamp_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLAMP && n_clr) |=> (r_integ == '0))
        else $error("integral not cleared on clamp");

    // a waiting result is not overwritten
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("pending result lost");

endmodule

`default_nettype wire
